// File: rtl/roi_pixel_statistics_unit_macros.svh
// assertion macros shared by the checker
`ifndef ROI_PIXEL_STATISTICS_UNIT_MACROS_SVH
`define ROI_PIXEL_STATISTICS_UNIT_MACROS_SVH

// same-cycle implication, masked during reset
`define RPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, masked during reset
`define RPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// shared types and constants of the roi pixel statistics unit
// ----------------------------------------------------------------------------
package rps_pkg;

    localparam int CFG_W = 13;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_LEFT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_HEIGHT  = 3'd4;

    localparam int SUM_W = 33;
    localparam int SQ_W  = 41;
    localparam int CNT_W = 25;
    localparam int QUO_W = 32;
    localparam int REM_W = CNT_W + 1;
    localparam int ROOT_W = 16;
    localparam int SREM_W = 20;

    typedef struct packed {
        logic start;
        logic div_step;
        logic load_msq;
        logic mul;
        logic sqrt_load;
        logic sqrt_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_status;

endpackage

// File: rtl/roi_pixel_statistics_unit.sv
// ----------------------------------------------------------------------------
// roi_pixel_statistics_unit
// Pixels are taken one per clock while o_ready is high. A pixel flagged
// frame_end starts the statistics pass: two restoring divisions on the
// shared divider with a load step between them, a squaring step, a
// subtraction step and a bit-serial square root; the result transaction is
// offered once the previous result has been taken. Pixels of the next frame
// are still taken during that pass; only a further frame_end pixel waits
// until the pass is over and the previous result has been taken.
// ----------------------------------------------------------------------------
module roi_pixel_statistics_unit #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rps_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_pixel,
    input  logic                          i_frame_end,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [15:0]                   o_mean_q8,
    output logic [14:0]                   o_stddev_q8,
    output logic [7:0]                    o_min_pixel,
    output logic [7:0]                    o_max_pixel,
    output logic                          o_region_empty
);
    rps_pkg::t_cmd    cmd;
    rps_pkg::t_status status;
    logic [rps_pkg::SUM_W-1:0] sum;
    logic [rps_pkg::SQ_W-1:0]  sq;
    logic [rps_pkg::CNT_W-1:0] cnt;
    logic [7:0] mn, mx;
    logic busy, take;

    assign o_ready = !((busy || o_valid) && i_frame_end);
    assign take    = i_valid && o_ready;

    rps_accum #(.MAX_DIMENSION(MAX_DIMENSION)) u_accum (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_take(take), .i_pixel(i_pixel), .i_frame_end(i_frame_end),
        .o_sum(sum), .o_sq(sq), .o_cnt(cnt), .o_min(mn), .o_max(mx)
    );

    rps_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(take && i_frame_end), .i_status(status),
        .o_cmd(cmd), .o_busy(busy)
    );

    rps_arith u_arith (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_status(status),
        .i_sum(sum), .i_sq(sq), .i_cnt(cnt), .i_min(mn), .i_max(mx),
        .i_out_ready(i_ready), .o_out_valid(o_valid),
        .o_mean_q8(o_mean_q8), .o_stddev_q8(o_stddev_q8),
        .o_min_pixel(o_min_pixel), .o_max_pixel(o_max_pixel),
        .o_region_empty(o_region_empty)
    );
endmodule

// File: rtl/rps_accum.sv
// ----------------------------------------------------------------------------
// rps_accum
// raster position tracking, region test and per-frame accumulators
// ----------------------------------------------------------------------------
module rps_accum #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [rps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rps_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_take,
    input  logic [7:0]                   i_pixel,
    input  logic                         i_frame_end,
    output logic [rps_pkg::SUM_W-1:0]    o_sum,
    output logic [rps_pkg::SQ_W-1:0]     o_sq,
    output logic [rps_pkg::CNT_W-1:0]    o_cnt,
    output logic [7:0]                   o_min,
    output logic [7:0]                   o_max
);
    localparam int CW = $clog2(MAX_DIMENSION);
    localparam int EW = (CW + 1 > 14) ? CW + 1 : 14;
    localparam logic [EW-1:0] MAXD = EW'(MAX_DIMENSION);
    localparam logic [CW-1:0] ROW_LAST = CW'(MAX_DIMENSION - 1);

    logic [12:0] r_fw, r_rw, r_rh;
    logic [11:0] r_rl, r_rt;
    logic [CW-1:0] r_col, r_row, n_col, n_row;
    logic [rps_pkg::SUM_W-1:0] r_sum, n_sum;
    logic [rps_pkg::SQ_W-1:0]  r_sq, n_sq;
    logic [rps_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0] r_min, r_max, n_min, n_max;
    logic [EW-1:0] effw, col_inc;
    logic [15:0] px_sq;
    logic in_roi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= 13'd640;
            r_rl <= '0;
            r_rt <= '0;
            r_rw <= 13'd64;
            r_rh <= 13'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rps_pkg::REG_FRAME_WIDTH: r_fw <= i_cfg_data;
                rps_pkg::REG_ROI_LEFT:    r_rl <= i_cfg_data[11:0];
                rps_pkg::REG_ROI_TOP:     r_rt <= i_cfg_data[11:0];
                rps_pkg::REG_ROI_WIDTH:   r_rw <= i_cfg_data;
                rps_pkg::REG_ROI_HEIGHT:  r_rh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        effw = (r_fw == '0 || EW'(r_fw) > MAXD) ? MAXD : EW'(r_fw);
        in_roi = (EW'(r_col) >= EW'(r_rl)) && (EW'(r_col) < EW'(r_rl) + EW'(r_rw)) &&
                 (EW'(r_row) >= EW'(r_rt)) && (EW'(r_row) < EW'(r_rt) + EW'(r_rh));
        px_sq = 16'(i_pixel) * 16'(i_pixel);
        n_sum = r_sum;
        n_sq  = r_sq;
        n_cnt = r_cnt;
        n_min = r_min;
        n_max = r_max;
        if (in_roi && r_cnt != '1) begin
            n_cnt = r_cnt + 1'b1;
            n_sum = r_sum + rps_pkg::SUM_W'(i_pixel);
            n_sq  = r_sq + rps_pkg::SQ_W'(px_sq);
            if (i_pixel < r_min) n_min = i_pixel;
            if (i_pixel > r_max) n_max = i_pixel;
        end
        col_inc = EW'(r_col) + 1'b1;
        n_col = CW'(col_inc);
        n_row = r_row;
        if (col_inc >= effw) begin
            n_col = '0;
            n_row = (r_row == ROW_LAST) ? '0 : r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_frame_end)) begin
            r_col <= '0;
            r_row <= '0;
            r_sum <= '0;
            r_sq  <= '0;
            r_cnt <= '0;
            r_min <= 8'd255;
            r_max <= '0;
        end else if (i_take) begin
            r_col <= n_col;
            r_row <= n_row;
            r_sum <= n_sum;
            r_sq  <= n_sq;
            r_cnt <= n_cnt;
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    // frame totals including the current pixel
    assign o_sum = n_sum;
    assign o_sq  = n_sq;
    assign o_cnt = n_cnt;
    assign o_min = n_min;
    assign o_max = n_max;
endmodule

// File: rtl/rps_arith.sv
// ----------------------------------------------------------------------------
// rps_arith
// end-of-frame datapath: shared restoring divider, squarer, bit-serial root
// and result register
// ----------------------------------------------------------------------------
module rps_arith (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rps_pkg::t_cmd             i_cmd,
    output rps_pkg::t_status          o_status,
    input  logic [rps_pkg::SUM_W-1:0] i_sum,
    input  logic [rps_pkg::SQ_W-1:0]  i_sq,
    input  logic [rps_pkg::CNT_W-1:0] i_cnt,
    input  logic [7:0]                i_min,
    input  logic [7:0]                i_max,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [15:0]               o_mean_q8,
    output logic [14:0]               o_stddev_q8,
    output logic [7:0]                o_min_pixel,
    output logic [7:0]                o_max_pixel,
    output logic                      o_region_empty
);
    logic [rps_pkg::SQ_W-1:0]   r_sq;
    logic [rps_pkg::CNT_W-1:0]  r_cnt;
    logic [7:0]                 r_min, r_max;
    logic [rps_pkg::REM_W-1:0]  r_rem, div_t;
    logic [rps_pkg::QUO_W-1:0]  r_quo, r_msq, r_msqm, r_sv;
    logic [15:0]                r_mean;
    logic [rps_pkg::ROOT_W-1:0] r_root;
    logic [rps_pkg::SREM_W-1:0] r_srem, sq_t, sq_trial;
    logic                       div_ge, sq_ge, r_out_valid;

    always_comb begin
        div_t  = {r_rem[rps_pkg::REM_W-2:0], r_quo[rps_pkg::QUO_W-1]};
        div_ge = div_t >= rps_pkg::REM_W'(r_cnt);
        sq_t     = {r_srem[rps_pkg::SREM_W-3:0], r_sv[rps_pkg::QUO_W-1 -: 2]};
        sq_trial = {2'b00, r_root, 2'b01};
        sq_ge    = sq_t >= sq_trial;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sq  <= i_sq;
            r_cnt <= i_cnt;
            r_min <= i_min;
            r_max <= i_max;
            r_rem <= rps_pkg::REM_W'(i_sum[32:24]);
            r_quo <= {i_sum[23:0], 8'd0};
        end else if (i_cmd.load_msq) begin
            r_mean <= r_quo[15:0];
            r_rem  <= rps_pkg::REM_W'(r_sq[40:16]);
            r_quo  <= {r_sq[15:0], 16'd0};
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_t - rps_pkg::REM_W'(r_cnt) : div_t;
            r_quo <= {r_quo[rps_pkg::QUO_W-2:0], div_ge};
        end
        if (i_cmd.mul) begin
            r_msq  <= r_quo;
            r_msqm <= r_mean * r_mean;
        end
        if (i_cmd.sqrt_load) begin
            r_sv   <= (r_msq > r_msqm) ? r_msq - r_msqm : '0;
            r_root <= '0;
            r_srem <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_srem <= sq_ge ? sq_t - sq_trial : sq_t;
            r_root <= {r_root[rps_pkg::ROOT_W-2:0], sq_ge};
            r_sv   <= {r_sv[rps_pkg::QUO_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_min_pixel <= r_min;
            o_max_pixel <= r_max;
            if (r_cnt == '0) begin
                o_mean_q8      <= '0;
                o_stddev_q8    <= '0;
                o_region_empty <= 1'b1;
            end else begin
                o_mean_q8      <= r_mean;
                o_stddev_q8    <= r_root[15] ? 15'h7fff : r_root[14:0];
                o_region_empty <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status.out_full = r_out_valid;
endmodule

// File: rtl/rps_ctrl.sv
// ----------------------------------------------------------------------------
// rps_ctrl
// sequencer for the end-of-frame divide, square and root
// ----------------------------------------------------------------------------
module rps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  rps_pkg::t_status i_status,
    output rps_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIVM = 3'd1;
    localparam logic [2:0] S_LDQ  = 3'd2;
    localparam logic [2:0] S_DIVQ = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_SUB  = 3'd5;
    localparam logic [2:0] S_SQRT = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] r_state, n_state;
    logic [4:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step + 1'b1;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (i_start) begin
                    o_cmd.start = 1'b1;
                    n_state = S_DIVM;
                end
            end
            S_DIVM: begin
                o_cmd.div_step = 1'b1;
                if (r_step == 5'd31) n_state = S_LDQ;
            end
            S_LDQ: begin
                o_cmd.load_msq = 1'b1;
                n_step = '0;
                n_state = S_DIVQ;
            end
            S_DIVQ: begin
                o_cmd.div_step = 1'b1;
                if (r_step == 5'd31) n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_SUB;
            end
            S_SUB: begin
                o_cmd.sqrt_load = 1'b1;
                n_step = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_step == 5'd15) n_state = S_OUT;
            end
            S_OUT: begin
                // wait for the result register to drain
                if (!i_status.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_busy = r_state != S_IDLE;
endmodule

// File: rtl/rps_checker.sv
// ----------------------------------------------------------------------------
// rps_checker
// port-level checks on the result transactions
// ----------------------------------------------------------------------------
`include "roi_pixel_statistics_unit_macros.svh"

module rps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_mean_q8,
    input logic [14:0] o_stddev_q8,
    input logic [7:0]  o_min_pixel,
    input logic [7:0]  o_max_pixel,
    input logic        o_region_empty
);
    `RPS_ASSERT_IMP(a_empty_values, i_clk, i_rst_n, o_valid && o_region_empty, o_mean_q8 == 16'd0 && o_stddev_q8 == 15'd0 && o_min_pixel == 8'd255 && o_max_pixel == 8'd0)
    `RPS_ASSERT_IMP(a_min_le_max, i_clk, i_rst_n, o_valid && !o_region_empty, o_min_pixel <= o_max_pixel)
    // integer part of the mean lies between the extremes
    `RPS_ASSERT_IMP(a_mean_range, i_clk, i_rst_n, o_valid && !o_region_empty, o_mean_q8[15:8] >= o_min_pixel && o_mean_q8[15:8] <= o_max_pixel)
    `RPS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_mean_q8) && $stable(o_stddev_q8))
endmodule

bind roi_pixel_statistics_unit rps_checker u_rps_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_mean_q8(o_mean_q8), .o_stddev_q8(o_stddev_q8), .o_min_pixel(o_min_pixel),
    .o_max_pixel(o_max_pixel), .o_region_empty(o_region_empty)
);

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Feeds raster frames into the roi pixel statistics unit and checks every
// statistics transaction against a predictor held in a small scoreboard.
// Phases change the frame and region registers while the unit is idle, and
// both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct {
        bit [15:0] mean;
        bit [14:0] sdev;
        bit [7:0]  min_px;
        bit [7:0]  max_px;
        bit        empty;
    } t_stats;

    class roi_stats_board;
        bit [12:0] frame_w = 13'd640;
        bit [11:0] left = 12'd0;
        bit [11:0] top = 12'd0;
        bit [12:0] roi_w = 13'd64;
        bit [12:0] roi_h = 13'd64;
        int unsigned col = 0;
        int unsigned row = 0;
        int unsigned cnt = 0;
        longint unsigned sum = 0;
        longint unsigned sq_sum = 0;
        bit [7:0] run_min = 8'd255;
        bit [7:0] run_max = 8'd0;
        t_stats expected_stats[$];
        int errors = 0;

        function void set_reg(bit [rps_pkg::CFG_IDX_W-1:0] idx,
                              bit [rps_pkg::CFG_W-1:0] val);
            case (idx)
                rps_pkg::REG_FRAME_WIDTH: frame_w = val;
                rps_pkg::REG_ROI_LEFT:    left = val[11:0];
                rps_pkg::REG_ROI_TOP:     top = val[11:0];
                rps_pkg::REG_ROI_WIDTH:   roi_w = val;
                rps_pkg::REG_ROI_HEIGHT:  roi_h = val;
                default: ;
            endcase
        endfunction

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= v) r = t;
            end
            return r;
        endfunction

        function void note_pixel(bit [7:0] px, bit last);
            int unsigned effw;
            bit hit;
            t_stats s;
            longint unsigned m;
            longint unsigned msq;
            longint unsigned var_q;
            longint unsigned sd;
            effw = frame_w;
            if (effw == 0 || effw > 4096) effw = 4096;
            hit = col >= left && col < int'(left) + int'(roi_w) &&
                  row >= top && row < int'(top) + int'(roi_h);
            if (hit && cnt < 32'h1FF_FFFF) begin
                cnt++;
                sum += px;
                sq_sum += px * px;
                if (px < run_min) run_min = px;
                if (px > run_max) run_max = px;
            end
            col++;
            if (col >= effw) begin
                col = 0;
                row = (row + 1) % 4096;
            end
            if (!last) return;
            if (cnt == 0) begin
                s = '{16'd0, 15'd0, 8'd255, 8'd0, 1'b1};
            end else begin
                m = (sum << 8) / cnt;
                msq = (sq_sum << 16) / cnt;
                var_q = msq > m * m ? msq - m * m : 0;
                sd = root_floor(var_q);
                if (sd > 32767) sd = 32767;
                s = '{m[15:0], sd[14:0], run_min, run_max, 1'b0};
            end
            expected_stats.push_back(s);
            col = 0;
            row = 0;
            cnt = 0;
            sum = 0;
            sq_sum = 0;
            run_min = 8'd255;
            run_max = 8'd0;
        endfunction

        function void check_result(t_stats got);
            t_stats e;
            if (expected_stats.size() == 0) begin
                $display("%0t: unexpected statistics transaction mean %0d", $time, got.mean);
                errors++;
                return;
            end
            e = expected_stats.pop_front();
            if (got.mean != e.mean) begin
                $display("%0t: mean_q8 expected %0d actual %0d", $time, e.mean, got.mean);
                errors++;
            end
            if (got.sdev != e.sdev) begin
                $display("%0t: stddev_q8 expected %0d actual %0d", $time, e.sdev, got.sdev);
                errors++;
            end
            if (got.min_px != e.min_px) begin
                $display("%0t: min_pixel expected %0d actual %0d", $time, e.min_px, got.min_px);
                errors++;
            end
            if (got.max_px != e.max_px) begin
                $display("%0t: max_pixel expected %0d actual %0d", $time, e.max_px, got.max_px);
                errors++;
            end
            if (got.empty != e.empty) begin
                $display("%0t: region_empty expected %0d actual %0d", $time, e.empty,
                         got.empty);
                errors++;
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [rps_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [rps_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic [7:0]                    i_pixel = 8'd0;
    logic                          i_frame_end = 1'b0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [15:0]                   o_mean_q8;
    logic [14:0]                   o_stddev_q8;
    logic [7:0]                    o_min_pixel;
    logic [7:0]                    o_max_pixel;
    logic                          o_region_empty;

    roi_stats_board sb = new();
    bit calm = 1'b0;
    int sent = 0;

    roi_pixel_statistics_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_pixel(i_pixel),
        .i_frame_end(i_frame_end),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_mean_q8(o_mean_q8),
        .o_stddev_q8(o_stddev_q8),
        .o_min_pixel(o_min_pixel),
        .o_max_pixel(o_max_pixel),
        .o_region_empty(o_region_empty)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // caller lowers the write enable after the last write of a group
    task automatic cfg_write(bit [rps_pkg::CFG_IDX_W-1:0] idx,
                             bit [rps_pkg::CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic send_pixel(bit [7:0] px, bit last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        i_frame_end <= last;
        do @(posedge i_clk); while (!o_ready);
        sb.note_pixel(px, last);
        sent++;
    endtask

    task automatic send_frame(int len);
        int style;
        bit [7:0] px;
        bit [7:0] base;
        style = $urandom_range(0, 5);
        base = 8'($urandom_range(0, 255));
        for (int k = 0; k < len; k++) begin
            case (style)
                0: px = base;
                1: px = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                2: px = base + 8'($urandom_range(0, 3));
                default: px = 8'($urandom_range(0, 255));
            endcase
            send_pixel(px, k == len - 1);
        end
    endtask

    // results trail the last frame_end by the statistics pass
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.expected_stats.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic bit [rps_pkg::CFG_W-1:0] pick_width();
        case ($urandom_range(0, 7))
            0: return 13'd0;
            1: return 13'd4096;
            2: return 13'h1FFF;
            3: return 13'd1;
            default: return rps_pkg::CFG_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic bit [rps_pkg::CFG_W-1:0] pick_offset();
        case ($urandom_range(0, 7))
            0: return 13'h0FFF;
            1: return rps_pkg::CFG_W'($urandom_range(0, 8191));
            2: return 13'd0;
            default: return rps_pkg::CFG_W'($urandom_range(0, 6));
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result('{o_mean_q8, o_stddev_q8, o_min_pixel, o_max_pixel,
                              o_region_empty});
    end

    initial begin
        int gap;
        forever begin
            gap = calm ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        int phase_items;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: extremes, a single pixel frame
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd128, 1'b1);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd0, 1'b1);
        wait_drained();

        // zero region size gives an empty region
        cfg_write(rps_pkg::REG_ROI_WIDTH, 13'd0);
        i_cfg_we <= 1'b0;
        send_pixel(8'd77, 1'b0);
        send_pixel(8'd200, 1'b1);
        wait_drained();

        // region beyond the visited positions
        cfg_write(rps_pkg::REG_FRAME_WIDTH, 13'd4);
        cfg_write(rps_pkg::REG_ROI_LEFT, 13'h0FFF);
        cfg_write(rps_pkg::REG_ROI_TOP, 13'd1);
        cfg_write(rps_pkg::REG_ROI_WIDTH, 13'h1FFF);
        cfg_write(rps_pkg::REG_ROI_HEIGHT, 13'd2);
        i_cfg_we <= 1'b0;
        for (int k = 0; k < 6; k++) send_pixel(8'($urandom_range(0, 255)), k == 5);
        wait_drained();

        while (sent < 1300) begin
            cfg_write(rps_pkg::REG_FRAME_WIDTH, pick_width());
            cfg_write(rps_pkg::REG_ROI_LEFT, pick_offset());
            cfg_write(rps_pkg::REG_ROI_TOP, pick_offset());
            cfg_write(rps_pkg::REG_ROI_WIDTH, pick_width());
            cfg_write(rps_pkg::REG_ROI_HEIGHT, pick_width());
            i_cfg_we <= 1'b0;
            calm = $urandom_range(0, 3) == 0;
            phase_items = 0;
            while (phase_items < 100) begin
                gap_len_block: begin
                    int len;
                    len = $urandom_range(0, 9) == 0 ? $urandom_range(60, 200)
                                                    : $urandom_range(1, 40);
                    send_frame(len);
                    phase_items += len;
                end
            end
            calm = 1'b0;
            wait_drained();
        end

        i_valid <= 1'b0;
        if (sb.errors == 0) begin
            $display("roi_pixel_statistics_unit test passed");
        end else begin
            $display("roi_pixel_statistics_unit test failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("roi_pixel_statistics_unit test failed");
        $finish;
    end

endmodule
